### hw/rtl/lrdb_pkg.sv
// shared constants and codes for the ray deflect and bin block
package lrdb_pkg;

    localparam int MAX_LENSES_DEF = 16;
    localparam int GRID_SIZE_DEF  = 512;
    localparam int COUNT_BITS_DEF = 32;

    localparam int OP_W      = 2;
    localparam int SLOT_W    = 4;
    localparam int Q_W       = 32;
    localparam int MASS_W    = 31;
    localparam int BADDR_W   = 18;
    localparam int BIN_W     = 9;
    localparam int CNT_OUT_W = 32;
    localparam int LCOUNT_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // per-lens arithmetic widths
    localparam int DIFF_W = 33;
    localparam int MAG_W  = 33;
    localparam int MULA_W = 34;
    localparam int MULP_W = MULA_W + MAG_W;
    localparam int DEN_W  = 66;
    localparam int NUM_W  = 79;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int QLO_W  = 58;
    localparam int TERM_W = QLO_W + 1;
    localparam int ACC_W  = 64;

    localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {QLO_W{1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_SHOOT = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHEAR       = 3'd0,
        REG_CONVERGENCE = 3'd1,
        REG_LENS_COUNT  = 3'd2,
        REG_HALF_WIDTH  = 3'd3,
        REG_BINS_UNIT   = 3'd4
    } cfg_reg_t;

endpackage

### hw/rtl/lens_ray_deflect_and_bin.sv
// point lens ray deflector with source-plane hit histogram, top level
//
//  channel | handshake            | contents
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | operation, lens slot and position, ray, bin address
//  out     | out_valid / out_stall| landed, singular, deflection, bin, counts
//  cfg     | cfg_valid / cfg_ready| register index and write data
//
//  a shot forms its operands per lens on the single shared multiplier, divides in the
//  shared one-bit-per-cycle divider for 79 quotient bits with both axes at once, and
//  accumulates; a lens at zero distance is skipped. a shot that lands also updates
//  its histogram bin.
//  after reset a clearing pass zeroes the histogram, during which in_stall is high;
//  cfg writes are always taken.
//  a finished result waits in the output register while the next request is taken.
module lens_ray_deflect_and_bin #(
    parameter int MAX_LENSES = lrdb_pkg::MAX_LENSES_DEF,
    parameter int GRID_SIZE  = lrdb_pkg::GRID_SIZE_DEF,
    parameter int COUNT_BITS = lrdb_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lrdb_pkg::OP_W-1:0]           operation,
    input  logic [lrdb_pkg::SLOT_W-1:0]         lens_slot,
    input  logic signed [lrdb_pkg::Q_W-1:0]     lens_pos_x,
    input  logic signed [lrdb_pkg::Q_W-1:0]     lens_pos_y,
    input  logic [lrdb_pkg::MASS_W-1:0]         lens_weight,
    input  logic signed [lrdb_pkg::Q_W-1:0]     ray_x,
    input  logic signed [lrdb_pkg::Q_W-1:0]     ray_y,
    input  logic [lrdb_pkg::BADDR_W-1:0]        bin_address,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                landed,
    output logic                                singular,
    output logic signed [lrdb_pkg::Q_W-1:0]     deflected_x,
    output logic signed [lrdb_pkg::Q_W-1:0]     deflected_y,
    output logic [lrdb_pkg::BIN_W-1:0]          bin_column,
    output logic [lrdb_pkg::BIN_W-1:0]          bin_row,
    output logic [lrdb_pkg::CNT_OUT_W-1:0]      bin_count,
    output logic [lrdb_pkg::CNT_OUT_W-1:0]      highest_count,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrdb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrdb_pkg::CFG_W-1:0]          cfg_data
);
    import lrdb_pkg::*;

    localparam int LENS_AW  = (MAX_LENSES > 1) ? $clog2(MAX_LENSES) : 1;
    localparam int LCW      = $clog2(MAX_LENSES + 1);
    localparam int LENS_DW  = 2 * Q_W + MASS_W;
    localparam int BIN_TOT  = GRID_SIZE * GRID_SIZE;
    localparam int HAW      = $clog2(BIN_TOT);
    localparam int GW       = $clog2(GRID_SIZE);
    localparam int RAWB_W   = 31;
    localparam int NPROD_W  = NUM_W - 16;

    typedef enum logic [20:0] {
        ST_CLEAR      = 21'h000001,
        ST_IDLE       = 21'h000002,
        ST_LIN_X      = 21'h000004,
        ST_LIN_Y      = 21'h000008,
        ST_LENS_RD    = 21'h000010,
        ST_LENS_DIFF  = 21'h000020,
        ST_SQ_X       = 21'h000040,
        ST_SQ_Y       = 21'h000080,
        ST_NUM_X      = 21'h000100,
        ST_NUM_Y      = 21'h000200,
        ST_DIV        = 21'h000400,
        ST_ACC        = 21'h000800,
        ST_FIN        = 21'h001000,
        ST_LAND       = 21'h002000,
        ST_BIN_X      = 21'h004000,
        ST_BIN_Y      = 21'h008000,
        ST_HIST_RD    = 21'h010000,
        ST_HIST_UPD   = 21'h020000,
        ST_READ_ISSUE = 21'h040000,
        ST_READ_TAKE  = 21'h080000,
        ST_EMIT       = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [Q_W-1:0]    shear_reg, conv_reg;
    logic [LCOUNT_W-1:0]      lcount_reg;
    logic [MASS_W-1:0]        half_reg, bpu_reg;

    // request and working registers
    logic signed [Q_W-1:0]    rx_reg, ry_reg;
    logic [BADDR_W-1:0]       raddr_reg;
    logic signed [ACC_W-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic [LCW-1:0]           idx_reg, idx_next, n_reg;
    logic                     sing_reg, sing_next;
    logic                     dxn_reg, dyn_reg;
    logic [MAG_W-1:0]         mx_reg, my_reg;
    logic [MASS_W-1:0]        mass_reg;
    logic [DEN_W-1:0]         sqx_reg, sqy_reg, den_reg;
    // mass times offset stays below 2^63
    logic [NPROD_W-1:0]       numx_reg;
    logic signed [Q_W-1:0]    xs_reg, ys_reg;
    logic [GW-1:0]            col_reg, row_reg;
    logic [COUNT_BITS-1:0]    peak_reg;
    logic [HAW-1:0]           clr_reg;

    // pending result
    logic                     res_land_reg, res_sing_reg;
    logic signed [Q_W-1:0]    res_x_reg, res_y_reg;
    logic [BIN_W-1:0]         res_col_reg, res_row_reg;
    logic [CNT_OUT_W-1:0]     res_cnt_reg;

    // output register
    logic                     out_valid_reg;
    logic                     out_land_reg, out_sing_reg;
    logic signed [Q_W-1:0]    out_x_reg, out_y_reg;
    logic [BIN_W-1:0]         out_col_reg, out_row_reg;
    logic [CNT_OUT_W-1:0]     out_cnt_reg, out_peak_reg;

    logic                     in_acc, out_free, last_lens;
    logic [31:0]              n_lim;

    // shared multiplier
    logic [MULA_W-1:0]        mul_a;
    logic [MAG_W-1:0]         mul_b;
    logic [MULP_W-1:0]        mul_p;

    // linear factors and magnitudes
    logic signed [Q_W+2:0]    fx, fy;
    logic [MULA_W-1:0]        fx_mag, fy_mag;
    logic [MAG_W-1:0]         rx_mag, ry_mag;
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [Q_W:0]      h_s, xw, yw;
    logic [Q_W-1:0]           ux, uy;
    logic [RAWB_W-1:0]        rawb;
    logic signed [ACC_W-1:0]  lin;
    logic                     land_now;

    // memories
    logic                     lens_we;
    logic [LENS_AW-1:0]       lens_waddr, lens_raddr;
    logic [LENS_DW-1:0]       lens_wdata, lens_rdata;
    logic                     hist_we;
    logic [HAW-1:0]           hist_waddr, hist_raddr, hit_addr;
    logic [COUNT_BITS-1:0]    hist_wdata, hist_rdata, cnt_inc;

    // divider
    logic                     div_start, div_done;
    logic [TERM_W-1:0]        quo_x, quo_y;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign last_lens = (idx_reg + 1'b1) == n_reg;
    assign n_lim     = ({27'd0, lcount_reg} > 32'(MAX_LENSES)) ? 32'(MAX_LENSES)
                                                              : {27'd0, lcount_reg};

    // linear map factors, 1 - kappa -/+ gamma
    assign fx     = (Q_W+3)'(65536) - (Q_W+3)'(shear_reg) - (Q_W+3)'(conv_reg);
    assign fy     = (Q_W+3)'(65536) + (Q_W+3)'(shear_reg) - (Q_W+3)'(conv_reg);
    assign fx_mag = fx[Q_W+2] ? MULA_W'(-fx) : MULA_W'(fx);
    assign fy_mag = fy[Q_W+2] ? MULA_W'(-fy) : MULA_W'(fy);
    assign rx_mag = rx_reg[Q_W-1] ? MAG_W'(-(MAG_W'(rx_reg))) : MAG_W'(rx_reg);
    assign ry_mag = ry_reg[Q_W-1] ? MAG_W'(-(MAG_W'(ry_reg))) : MAG_W'(ry_reg);

    // lens offsets from the fresh lens read
    assign dx = DIFF_W'(rx_reg) - DIFF_W'($signed(lens_rdata[LENS_DW-1 -: Q_W]));
    assign dy = DIFF_W'(ry_reg) - DIFF_W'($signed(lens_rdata[MASS_W +: Q_W]));

    // source square tests and bin offsets
    assign h_s = $signed({2'b00, half_reg});
    assign xw  = (Q_W+1)'(xs_reg);
    assign yw  = (Q_W+1)'(ys_reg);
    assign ux  = Q_W'(xw + h_s);
    assign uy  = Q_W'(yw + h_s);
    assign land_now = (xw > -h_s) && (xw < h_s) && (yw > -h_s) && (yw < h_s);

    assign hit_addr = HAW'(row_reg) * HAW'(GRID_SIZE) + HAW'(col_reg);
    assign cnt_inc  = (hist_rdata == '1) ? hist_rdata : hist_rdata + 1'b1;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LIN_X:
            begin
                mul_a = fx_mag;
                mul_b = rx_mag;
            end
            ST_LIN_Y:
            begin
                mul_a = fy_mag;
                mul_b = ry_mag;
            end
            ST_SQ_X:
            begin
                mul_a = MULA_W'(mx_reg);
                mul_b = mx_reg;
            end
            ST_SQ_Y:
            begin
                mul_a = MULA_W'(my_reg);
                mul_b = my_reg;
            end
            ST_NUM_X:
            begin
                mul_a = MULA_W'(mass_reg);
                mul_b = mx_reg;
            end
            ST_NUM_Y:
            begin
                mul_a = MULA_W'(mass_reg);
                mul_b = my_reg;
            end
            ST_BIN_X:
            begin
                mul_a = MULA_W'(ux);
                mul_b = MAG_W'(bpu_reg);
            end
            ST_BIN_Y:
            begin
                mul_a = MULA_W'(uy);
                mul_b = MAG_W'(bpu_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = MULP_W'(mul_a) * MULP_W'(mul_b);
        // product fits in 63 bits, integer part of the bin index
        rawb  = mul_p[62:32];
        lin   = ACC_W'(mul_p[MULP_W-1:16]);
    end

    // lens table: one word per slot holds x, y and mass
    assign lens_we    = in_acc && (op_t'(operation) == OP_LOAD)
                        && (32'(lens_slot) < 32'(MAX_LENSES));
    assign lens_waddr = LENS_AW'(lens_slot);
    assign lens_wdata = {lens_pos_x, lens_pos_y, lens_weight};
    assign lens_raddr = LENS_AW'(idx_reg);

    lrdb_ram #(
        .WIDTH (LENS_DW),
        .DEPTH (MAX_LENSES)
    ) u_lens_ram (
        .clk   (clk),
        .we    (lens_we),
        .waddr (lens_waddr),
        .wdata (lens_wdata),
        .raddr (lens_raddr),
        .rdata (lens_rdata)
    );

    // histogram: clearing pass or count update, reads for shot or bin read
    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = hit_addr;
        hist_wdata = cnt_inc;
        hist_raddr = hit_addr;
        if (state_reg == ST_CLEAR)
        begin
            hist_we    = 1'b1;
            hist_waddr = clr_reg;
            hist_wdata = '0;
        end
        else if (state_reg == ST_HIST_UPD)
        begin
            hist_we = 1'b1;
        end
        if (state_reg == ST_READ_ISSUE)
        begin
            hist_raddr = HAW'(raddr_reg);
        end
    end

    lrdb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BIN_TOT)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // both axes divide by the same squared distance
    assign div_start = (state_reg == ST_NUM_Y);

    lrdb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_x ({numx_reg, 16'd0}),
        .num_y ({mul_p[NPROD_W-1:0], 16'd0}),
        .den   (den_reg),
        .done  (div_done),
        .quo_x (quo_x),
        .quo_y (quo_y)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sing_next  = sing_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == HAW'(BIN_TOT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    sing_next = 1'b0;
                    idx_next  = '0;
                    unique case (op_t'(operation))
                        OP_SHOOT: state_next = ST_LIN_X;
                        OP_READ:  state_next = ST_READ_ISSUE;
                        OP_LOAD:  state_next = ST_EMIT;
                        OP_NONE:  state_next = ST_EMIT;
                        default:  state_next = ST_EMIT;
                    endcase
                end
            end
            ST_LIN_X:
            begin
                ax_next    = ((fx < 0) != rx_reg[Q_W-1]) ? -lin : lin;
                state_next = ST_LIN_Y;
            end
            ST_LIN_Y:
            begin
                ay_next    = ((fy < 0) != ry_reg[Q_W-1]) ? -lin : lin;
                state_next = (n_reg == '0) ? ST_FIN : ST_LENS_RD;
            end
            ST_LENS_RD:   state_next = ST_LENS_DIFF;
            ST_LENS_DIFF: state_next = ST_SQ_X;
            ST_SQ_X:
            begin
                // lens exactly on the ray: skip it and flag
                if ((mx_reg == '0) && (my_reg == '0))
                begin
                    sing_next  = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = last_lens ? ST_FIN : ST_LENS_RD;
                end
                else
                begin
                    state_next = ST_SQ_Y;
                end
            end
            ST_SQ_Y:  state_next = ST_NUM_X;
            ST_NUM_X: state_next = ST_NUM_Y;
            ST_NUM_Y: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                ax_next    = dxn_reg ? ax_reg + ACC_W'(quo_x) : ax_reg - ACC_W'(quo_x);
                ay_next    = dyn_reg ? ay_reg + ACC_W'(quo_y) : ay_reg - ACC_W'(quo_y);
                idx_next   = idx_reg + 1'b1;
                state_next = last_lens ? ST_FIN : ST_LENS_RD;
            end
            ST_FIN:  state_next = ST_LAND;
            ST_LAND: state_next = land_now ? ST_BIN_X : ST_EMIT;
            ST_BIN_X: state_next = ST_BIN_Y;
            ST_BIN_Y: state_next = ST_HIST_RD;
            ST_HIST_RD: state_next = ST_HIST_UPD;
            ST_HIST_UPD: state_next = ST_EMIT;
            ST_READ_ISSUE: state_next = ST_READ_TAKE;
            ST_READ_TAKE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            shear_reg     <= '0;
            conv_reg      <= '0;
            lcount_reg    <= '0;
            half_reg      <= MASS_W'(65536);
            bpu_reg       <= MASS_W'(16777216);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if ((state_reg == ST_HIST_UPD) && (cnt_inc > peak_reg))
            begin
                peak_reg <= cnt_inc;
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SHEAR:       shear_reg  <= $signed(cfg_data);
                    REG_CONVERGENCE: conv_reg   <= $signed(cfg_data);
                    REG_LENS_COUNT:  lcount_reg <= cfg_data[LCOUNT_W-1:0];
                    REG_HALF_WIDTH:  half_reg   <= cfg_data[MASS_W-1:0];
                    REG_BINS_UNIT:   bpu_reg    <= cfg_data[MASS_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        sing_reg <= sing_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        if (in_acc)
        begin
            rx_reg       <= ray_x;
            ry_reg       <= ray_y;
            raddr_reg    <= bin_address;
            n_reg        <= n_lim[LCW-1:0];
            res_land_reg <= 1'b0;
            res_sing_reg <= 1'b0;
            res_x_reg    <= '0;
            res_y_reg    <= '0;
            res_col_reg  <= '0;
            res_row_reg  <= '0;
            res_cnt_reg  <= '0;
        end
        if (state_reg == ST_LENS_DIFF)
        begin
            dxn_reg  <= dx[DIFF_W-1];
            dyn_reg  <= dy[DIFF_W-1];
            mx_reg   <= dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            my_reg   <= dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
            mass_reg <= lens_rdata[MASS_W-1:0];
        end
        if (state_reg == ST_SQ_X)
        begin
            sqx_reg <= mul_p[DEN_W-1:0];
        end
        if (state_reg == ST_SQ_Y)
        begin
            sqy_reg <= mul_p[DEN_W-1:0];
        end
        if (state_reg == ST_NUM_X)
        begin
            numx_reg <= mul_p[NPROD_W-1:0];
            den_reg  <= sqx_reg + sqy_reg;
        end
        if (state_reg == ST_FIN)
        begin
            xs_reg <= (ax_reg > ACC_W'(64'sd2147483647)) ? 32'sh7fffffff :
                      (ax_reg < -ACC_W'(64'sd2147483648)) ? 32'sh80000000 : Q_W'(ax_reg);
            ys_reg <= (ay_reg > ACC_W'(64'sd2147483647)) ? 32'sh7fffffff :
                      (ay_reg < -ACC_W'(64'sd2147483648)) ? 32'sh80000000 : Q_W'(ay_reg);
        end
        if (state_reg == ST_LAND)
        begin
            res_sing_reg <= sing_reg;
            res_x_reg    <= xs_reg;
            res_y_reg    <= ys_reg;
            res_land_reg <= land_now;
        end
        if (state_reg == ST_BIN_X)
        begin
            // column capped at the last bin
            col_reg <= (rawb > RAWB_W'(GRID_SIZE - 1)) ? GW'(GRID_SIZE - 1) : GW'(rawb);
        end
        if (state_reg == ST_BIN_Y)
        begin
            // row zero is the top of the grid
            row_reg <= (rawb >= RAWB_W'(GRID_SIZE)) ? '0 : GW'(RAWB_W'(GRID_SIZE - 1) - rawb);
        end
        if (state_reg == ST_HIST_UPD)
        begin
            res_col_reg <= BIN_W'(col_reg);
            res_row_reg <= BIN_W'(row_reg);
            res_cnt_reg <= CNT_OUT_W'(cnt_inc);
        end
        if (state_reg == ST_READ_TAKE)
        begin
            res_cnt_reg <= (32'(raddr_reg) < 32'(BIN_TOT)) ? CNT_OUT_W'(hist_rdata) : '0;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_land_reg <= res_land_reg;
            out_sing_reg <= res_sing_reg;
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_y_reg;
            out_col_reg  <= res_col_reg;
            out_row_reg  <= res_row_reg;
            out_cnt_reg  <= res_cnt_reg;
            out_peak_reg <= CNT_OUT_W'(peak_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign landed        = out_land_reg;
    assign singular      = out_sing_reg;
    assign deflected_x   = out_x_reg;
    assign deflected_y   = out_y_reg;
    assign bin_column    = out_col_reg;
    assign bin_row       = out_row_reg;
    assign bin_count     = out_cnt_reg;
    assign highest_count = out_peak_reg;

    // requests only enter an idle sequencer
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> state_reg == ST_IDLE)
        else $error("request taken while sequencer busy");

    // peak never falls
    a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak count decreased");

    // a landed ray always leaves a nonzero count
    a_land_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && landed |-> bin_count != '0)
        else $error("landed ray with zero bin count");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider result outside wait state");

endmodule

### hw/rtl/lrdb_ram.sv
// generic simple dual port ram with registered read
module lrdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/lrdb_div.sv
// two-lane restoring divider sharing one denominator, one bit per cycle
module lrdb_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lrdb_pkg::NUM_W-1:0]   num_x,
    input  logic [lrdb_pkg::NUM_W-1:0]   num_y,
    input  logic [lrdb_pkg::DEN_W-1:0]   den,
    output logic                         done,
    output logic [lrdb_pkg::TERM_W-1:0]  quo_x,
    output logic [lrdb_pkg::TERM_W-1:0]  quo_y
);
    import lrdb_pkg::*;

    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  nx_reg, nx_next, ny_reg, ny_next;
    logic [DEN_W-1:0]  remx_reg, remx_next, remy_reg, remy_next;
    logic [QLO_W-1:0]  qx_reg, qx_next, qy_reg, qy_next;
    logic              ovx_reg, ovx_next, ovy_reg, ovy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    shx, shy;
    logic              gex, gey, high_bit;

    always_comb
    begin
        shx      = {remx_reg, nx_reg[NUM_W-1]};
        shy      = {remy_reg, ny_reg[NUM_W-1]};
        gex      = shx >= {1'b0, den_reg};
        gey      = shy >= {1'b0, den_reg};
        high_bit = step_reg >= STEP_W'(QLO_W);
        nx_next   = nx_reg;
        ny_next   = ny_reg;
        remx_next = remx_reg;
        remy_next = remy_reg;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        ovx_next  = ovx_reg;
        ovy_next  = ovy_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            nx_next   = num_x;
            ny_next   = num_y;
            remx_next = '0;
            remy_next = '0;
            qx_next   = '0;
            qy_next   = '0;
            ovx_next  = 1'b0;
            ovy_next  = 1'b0;
            step_next = STEP_W'(NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            nx_next   = {nx_reg[NUM_W-2:0], 1'b0};
            ny_next   = {ny_reg[NUM_W-2:0], 1'b0};
            remx_next = gex ? DEN_W'(shx - {1'b0, den_reg}) : shx[DEN_W-1:0];
            remy_next = gey ? DEN_W'(shy - {1'b0, den_reg}) : shy[DEN_W-1:0];
            // quotient bits at or above the cap position only raise overflow
            qx_next   = {qx_reg[QLO_W-2:0], gex};
            qy_next   = {qy_reg[QLO_W-2:0], gey};
            ovx_next  = ovx_reg | (gex & high_bit);
            ovy_next  = ovy_reg | (gey & high_bit);
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
        end
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        ovx_reg  <= ovx_next;
        ovy_reg  <= ovy_next;
    end

    assign done  = done_reg;
    assign quo_x = ovx_reg ? TERM_CAP : {1'b0, qx_reg};
    assign quo_y = ovy_reg ? TERM_CAP : {1'b0, qy_reg};

endmodule

### verif/tb_top.sv
// self-checking testbench for the ray deflect and bin block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lrdb_pkg::*;

    // one request on the input channel
    typedef struct {
        op_t                op;
        logic [3:0]         slot;
        logic signed [31:0] lpx;
        logic signed [31:0] lpy;
        logic [30:0]        mass;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic [17:0]        addr;
    } request_t;

    // one result on the output channel
    typedef struct {
        logic               landed;
        logic               singular;
        logic signed [31:0] defl_x;
        logic signed [31:0] defl_y;
        logic [8:0]         col;
        logic [8:0]         row;
        logic [31:0]        count;
        logic [31:0]        peak;
    } result_t;

    // predicts each result from its own copy of lens table, registers and histogram
    class hit_scoreboard;
        logic signed [31:0] shear_q;
        logic signed [31:0] kappa_q;
        logic [4:0]         n_lens;
        logic [30:0]        half_w;
        logic [30:0]        bins_unit;
        logic [31:0]        lens_x[16];
        logic [31:0]        lens_y[16];
        logic [31:0]        lens_m[16];
        logic [31:0]        hits[int];
        logic [31:0]        peak;
        int                 hit_addrs[$];
        result_t            due[$];
        int                 errors;

        function new();
            shear_q   = 0;
            kappa_q   = 0;
            n_lens    = 0;
            half_w    = 31'd65536;
            bins_unit = 31'd16777216;
            peak      = 0;
            errors    = 0;
            foreach (lens_x[i])
            begin
                lens_x[i] = 0;
                lens_y[i] = 0;
                lens_m[i] = 0;
            end
        endfunction

        function void write_reg(cfg_reg_t idx, logic [31:0] d);
            case (idx)
                REG_SHEAR:       shear_q = d;
                REG_CONVERGENCE: kappa_q = d;
                REG_LENS_COUNT:  n_lens = d[4:0];
                REG_HALF_WIDTH:  half_w = d[30:0];
                REG_BINS_UNIT:   bins_unit = d[30:0];
                default: ;
            endcase
        endfunction

        function logic [127:0] mag(longint v);
            logic [127:0] m;
            m = (v < 0) ? 128'(-v) : 128'(v);
            return m;
        endfunction

        // shear and convergence part, rounded toward zero
        function longint linear(longint f, longint s);
            logic [127:0] p;
            p = (mag(f) * mag(s)) >> 16;
            return ((f < 0) != (s < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function result_t predict(request_t r);
            result_t      res;
            longint       rx, ry, ax, ay, dx, dy, tx, ty, h;
            logic [127:0] mx, my, den, num, q, cb, rb;
            int           n, col, row, addr;
            logic [31:0]  c;
            res = '{default: '0};
            case (r.op)
                OP_LOAD:
                begin
                    lens_x[r.slot] = r.lpx;
                    lens_y[r.slot] = r.lpy;
                    lens_m[r.slot] = {1'b0, r.mass};
                end
                OP_SHOOT:
                begin
                    rx = longint'(r.rx);
                    ry = longint'(r.ry);
                    ax = linear(64'sd65536 - longint'(shear_q) - longint'(kappa_q), rx);
                    ay = linear(64'sd65536 + longint'(shear_q) - longint'(kappa_q), ry);
                    n  = (n_lens > 16) ? 16 : int'(n_lens);
                    for (int i = 0; i < n; i++)
                    begin
                        dx  = rx - longint'($signed(lens_x[i]));
                        dy  = ry - longint'($signed(lens_y[i]));
                        mx  = mag(dx);
                        my  = mag(dy);
                        den = mx * mx + my * my;
                        if (den == 0)
                        begin
                            // lens sits exactly on the ray
                            res.singular = 1'b1;
                            continue;
                        end
                        num = 128'(lens_m[i]) * mx * 128'd65536;
                        q   = num / den;
                        if (q > (128'd1 << 58))
                            q = 128'd1 << 58;
                        tx  = longint'(q[63:0]);
                        num = 128'(lens_m[i]) * my * 128'd65536;
                        q   = num / den;
                        if (q > (128'd1 << 58))
                            q = 128'd1 << 58;
                        ty  = longint'(q[63:0]);
                        ax  -= (dx < 0) ? -tx : tx;
                        ay  -= (dy < 0) ? -ty : ty;
                    end
                    ax = sat32(ax);
                    ay = sat32(ay);
                    res.defl_x = ax[31:0];
                    res.defl_y = ay[31:0];
                    h = longint'(half_w);
                    if (ax > -h && ax < h && ay > -h && ay < h)
                    begin
                        cb  = (128'(ax + h) * 128'(bins_unit)) >> 32;
                        rb  = (128'(ay + h) * 128'(bins_unit)) >> 32;
                        col = (cb > 511) ? 511 : int'(cb);
                        row = (rb >= 512) ? 0 : 511 - int'(rb);
                        addr = row * 512 + col;
                        c = hits.exists(addr) ? hits[addr] : 32'd0;
                        if (c != 32'hFFFF_FFFF)
                            c++;
                        hits[addr] = c;
                        hit_addrs.push_back(addr);
                        if (c > peak)
                            peak = c;
                        res.landed = 1'b1;
                        res.col    = col[8:0];
                        res.row    = row[8:0];
                        res.count  = c;
                    end
                end
                OP_READ:
                    res.count = hits.exists(int'(r.addr)) ? hits[int'(r.addr)] : 32'd0;
                default: ;
            endcase
            res.peak = peak;
            return res;
        endfunction

        function void note_request(request_t r);
            due.push_back(predict(r));
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] g);
            if (e !== g)
            begin
                $error("%s mismatch: expected %0h actual %0h", name, e, g);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (due.size() == 0)
            begin
                $error("result with no request waiting");
                errors++;
                return;
            end
            e = due.pop_front();
            cmp("landed", e.landed, got.landed);
            cmp("singular", e.singular, got.singular);
            cmp("deflected_x", e.defl_x, got.defl_x);
            cmp("deflected_y", e.defl_y, got.defl_y);
            cmp("bin_column", e.col, got.col);
            cmp("bin_row", e.row, got.row);
            cmp("bin_count", e.count, got.count);
            cmp("highest_count", e.peak, got.peak);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [OP_W-1:0]    operation;
    logic [3:0]         lens_slot;
    logic signed [31:0] lens_pos_x;
    logic signed [31:0] lens_pos_y;
    logic [30:0]        lens_weight;
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
    logic [17:0]        bin_address;
    logic               out_valid;
    logic               out_stall;
    logic               landed;
    logic               singular;
    logic signed [31:0] deflected_x;
    logic signed [31:0] deflected_y;
    logic [8:0]         bin_column;
    logic [8:0]         bin_row;
    logic [31:0]        bin_count;
    logic [31:0]        highest_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    hit_scoreboard sb;
    int            send_idle_pct;   // sender gap chance per cycle, percent
    int            stall_pct;       // receiver stall chance per cycle, percent
    int            results_seen;
    bit            hold_done;

    lens_ray_deflect_and_bin u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .lens_slot     (lens_slot),
        .lens_pos_x    (lens_pos_x),
        .lens_pos_y    (lens_pos_y),
        .lens_weight   (lens_weight),
        .ray_x         (ray_x),
        .ray_y         (ray_y),
        .bin_address   (bin_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .landed        (landed),
        .singular      (singular),
        .deflected_x   (deflected_x),
        .deflected_y   (deflected_y),
        .bin_column    (bin_column),
        .bin_row       (bin_row),
        .bin_count     (bin_count),
        .highest_count (highest_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result monitor, samples on the rising edge
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.landed   = landed;
            got.singular = singular;
            got.defl_x   = deflected_x;
            got.defl_y   = deflected_y;
            got.col      = bin_column;
            got.row      = bin_row;
            got.count    = bin_count;
            got.peak     = highest_count;
            sb.check_result(got);
            results_seen++;
        end
    end

    // receiver: random stalls, plus one long hold-off early on so the
    // block backs up and stalls its request side while requests keep coming
    initial
    begin
        out_stall = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 5)
            begin
                hold_done = 1'b1;
                for (int k = 0; k < 2500; k++)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(1, 100) <= stall_pct);
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #96_000_000;
        $display("FAIL lens_ray_deflect_and_bin");
        $finish;
    end

    // one config write, taken when valid and ready meet
    task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // offer one request, with random sender gaps, and wait for acceptance
    task automatic send(request_t r);
        @(negedge clk);
        while ($urandom_range(1, 100) <= send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        operation   <= r.op;
        lens_slot   <= r.slot;
        lens_pos_x  <= r.lpx;
        lens_pos_y  <= r.lpy;
        lens_weight <= r.mass;
        ray_x       <= r.rx;
        ray_y       <= r.ry;
        bin_address <= r.addr;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // wait for every pending result, then let the block settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic request_t blank(op_t op);
        request_t r;
        r = '{op: op, slot: 4'($urandom), lpx: $urandom, lpy: $urandom,
              mass: 31'($urandom), rx: $urandom, ry: $urandom, addr: 18'($urandom)};
        return r;
    endfunction

    // value within +-span
    function automatic logic signed [31:0] near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_load(int slot, logic [31:0] x, logic [31:0] y, logic [30:0] m);
        request_t r;
        r = blank(OP_LOAD);
        r.slot = 4'(slot);
        r.lpx  = x;
        r.lpy  = y;
        r.mass = m;
        send(r);
    endtask

    task automatic send_shot(logic [31:0] x, logic [31:0] y);
        request_t r;
        r = blank(OP_SHOOT);
        r.rx = x;
        r.ry = y;
        send(r);
    endtask

    task automatic send_read(logic [17:0] a);
        request_t r;
        r = blank(OP_READ);
        r.addr = a;
        send(r);
    endtask

    task automatic set_regs(logic [31:0] g, logic [31:0] k, logic [31:0] n,
                            logic [31:0] h, logic [31:0] b);
        write_reg(REG_SHEAR, g);
        write_reg(REG_CONVERGENCE, k);
        write_reg(REG_LENS_COUNT, n);
        write_reg(REG_HALF_WIDTH, h);
        write_reg(REG_BINS_UNIT, b);
    endtask

    // mixed random traffic; most shots land near the lenses and the source square
    task automatic run_random(int items);
        request_t r;
        int       pick, n, i;
        for (int k = 0; k < items; k++)
        begin
            pick = $urandom_range(1, 100);
            n = (sb.n_lens > 16) ? 16 : int'(sb.n_lens);
            if (pick <= 10)
            begin
                r = blank(OP_LOAD);
                if ($urandom_range(1, 100) <= 80)
                begin
                    r.lpx  = near(196608);
                    r.lpy  = near(196608);
                    r.mass = 31'($urandom_range(0, 4096));
                end
            end
            else if (pick <= 70)
            begin
                r = blank(OP_SHOOT);
                pick = $urandom_range(1, 100);
                if (pick <= 60)
                begin
                    r.rx = near(98304);
                    r.ry = near(98304);
                end
                else if (pick <= 80 && n > 0)
                begin
                    // exactly on a lens, or one step off it
                    i = $urandom_range(0, n - 1);
                    r.rx = sb.lens_x[i];
                    r.ry = sb.lens_y[i];
                    if ($urandom_range(0, 2) == 0)
                        r.rx = r.rx + 1;
                end
            end
            else if (pick <= 95)
            begin
                r = blank(OP_READ);
                if (sb.hit_addrs.size() != 0 && $urandom_range(0, 3) != 0)
                    r.addr = 18'(sb.hit_addrs[$urandom_range(0, sb.hit_addrs.size() - 1)]);
            end
            else
                r = blank(OP_NONE);
            send(r);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_NONE;
        lens_slot     = '0;
        lens_pos_x    = '0;
        lens_pos_y    = '0;
        lens_weight   = '0;
        ray_x         = '0;
        ray_y         = '0;
        bin_address   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SHEAR;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        results_seen  = 0;
        hold_done     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fill every lens slot first, a lens at the origin in slot 0, extremes in slots 1 and 2
        set_regs(32'd0, 32'd0, 32'd0, 32'd65536, 32'd16777216);
        send_load(0, 32'd0, 32'd0, 31'd65536);
        send_load(1, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_load(2, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
        for (int s = 3; s < 16; s++)
            send_load(s, near(131072), near(131072), 31'($urandom_range(0, 8192)));
        send_shot(32'd0, 32'd0);
        send_shot(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_shot(32'h8000_0000, 32'h8000_0000);
        send_shot(-32'sd1, 32'sd1);
        send_read(18'h3FFFF);
        send_read(18'(255 * 512 + 256));
        send(blank(OP_NONE));
        drain();

        // directed lens cases: ray on a lens, ray one step off a heavy lens
        set_regs(32'd0, 32'd0, 32'd3, 32'd65536, 32'd16777216);
        send_shot(32'd0, 32'd0);
        send_shot(32'd1, 32'd0);
        send_shot(32'h7FFF_FFFF, 32'h8000_0001);
        send_shot(32'h8000_0000, 32'h7FFF_FFFF);
        run_random(100);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            case (p)
                0: set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'd16, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF);
                1: set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
                2: set_regs(near(8192), near(8192), 32'd31, 32'd65536, 32'd16777216);
                default: set_regs(near(8192), near(8192), $urandom_range(1, 5),
                                  ($urandom_range(0, 1) ? 32'd65536 :
                                   $urandom_range(16384, 131072)),
                                  ($urandom_range(0, 1) ? 32'd16777216 :
                                   $urandom_range(1, 33554432)));
            endcase
            run_random(118);
            drain();
        end

        if (sb.errors == 0)
            $display("PASS lens_ray_deflect_and_bin");
        else
            $display("FAIL lens_ray_deflect_and_bin");
        $finish;
    end

endmodule

### sim.f
hw/rtl/lrdb_pkg.sv
hw/rtl/lrdb_ram.sv
hw/rtl/lrdb_div.sv
hw/rtl/lens_ray_deflect_and_bin.sv
verif/tb_top.sv
